>>> src/four_digit_display_serial_writer_core_macros.svh
// Assertion macros for the four-digit display serial writer.
// Used by the top level; expects i_clk and i_rst_n in scope.
`ifndef FOUR_DIGIT_DISPLAY_SERIAL_WRITER_CORE_MACROS_SVH
`define FOUR_DIGIT_DISPLAY_SERIAL_WRITER_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define FDSW_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define FDSW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

>>> src/fdsw_pkg.sv
// Shared types and constants for the four-digit display serial writer.
// No dependencies; used by the sequencer and the top level.
package fdsw_pkg;

    localparam logic [7:0] CMD_DATA_SET  = 8'h40;
    localparam logic [7:0] CMD_ADDR_SET  = 8'hC0;
    localparam logic [7:0] CMD_DISP_CTRL = 8'h88;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    // Pin levels and status produced by one sequencer step.
    typedef struct packed {
        logic clock_pin;
        logic data_pin;
        logic data_drive;
        logic busy_res;
        logic transfer_done;
    } t_pins;

    // Decimal digit to segment pattern; codes above nine are dark.
    function automatic logic [6:0] seg_code(input logic [3:0] digit);
        logic [6:0] code;
        unique case (digit)
            4'd0:    code = 7'h3F;
            4'd1:    code = 7'h06;
            4'd2:    code = 7'h5B;
            4'd3:    code = 7'h4F;
            4'd4:    code = 7'h66;
            4'd5:    code = 7'h6D;
            4'd6:    code = 7'h7D;
            4'd7:    code = 7'h07;
            4'd8:    code = 7'h7F;
            4'd9:    code = 7'h6F;
            default: code = 7'h00;
        endcase
        return code;
    endfunction

endpackage

>>> src/fdsw_seq.sv
// Pin-phase sequencer of the display writer: frames, bytes, bits, acknowledge.
// Depends on fdsw_pkg; advances one phase per accepted tick item.
module fdsw_seq #(
    parameter int DIGIT_COUNT = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  logic             i_kind,
    input  logic [3:0]       i_digit_thousands,
    input  logic [3:0]       i_digit_hundreds,
    input  logic [3:0]       i_digit_tens,
    input  logic [3:0]       i_digit_units,
    input  logic             i_blank_request,
    input  logic             i_data_line_in,
    input  logic [2:0]       i_brightness,
    output fdsw_pkg::t_pins  o_pins
);
    import fdsw_pkg::*;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_START_A,
        PH_START_B,
        PH_START_C,
        PH_BIT_LOW,
        PH_BIT_HIGH,
        PH_ACK_REL,
        PH_ACK_LOW,
        PH_ACK_HIGH,
        PH_ACK_END,
        PH_STOP_A,
        PH_STOP_B,
        PH_ARMED
    } t_phase;

    localparam logic [1:0] FRAME_DATA = 2'd0;
    localparam logic [1:0] FRAME_ADDR = 2'd1;
    localparam logic [1:0] FRAME_DISP = 2'd2;
    localparam logic [3:0] ADDR_FRAME_BYTES = 4'(DIGIT_COUNT + 1);

    t_phase     r_phase, n_phase;
    logic [1:0] r_frame, n_frame;
    logic [2:0] r_byte_idx, n_byte_idx;
    logic [2:0] r_bit_idx, n_bit_idx;
    logic [7:0] r_shift, n_shift;
    logic       r_blank, n_blank;
    logic       r_clock, n_clock;
    logic       r_data, n_data;
    logic       n_done;
    logic [6:0] r_segment_store [DIGIT_COUNT];

    logic [3:0] w_digit [4];
    logic       w_load;
    logic       w_tick;
    logic [2:0] w_byte_sel;
    logic [3:0] w_frame_bytes;
    logic [6:0] w_store_byte;
    logic [7:0] w_byte;
    logic       w_last_frame;
    logic       w_drive;

    assign w_digit[0] = i_digit_thousands;
    assign w_digit[1] = i_digit_hundreds;
    assign w_digit[2] = i_digit_tens;
    assign w_digit[3] = i_digit_units;

    assign w_load = i_step && (i_kind == KIND_LOAD) && (r_phase == PH_IDLE);
    assign w_tick = i_step && (i_kind == KIND_TICK);

    // Byte about to be loaded: the first byte of the frame after the start,
    // otherwise the one following the byte just acknowledged.
    assign w_byte_sel    = (r_phase == PH_START_C) ? 3'd0 : r_byte_idx + 3'd1;
    assign w_frame_bytes = (r_frame == FRAME_ADDR) ? ADDR_FRAME_BYTES : 4'd1;
    assign w_last_frame  = r_blank ? (r_frame >= FRAME_ADDR) : (r_frame >= FRAME_DISP);

    always_comb begin
        w_store_byte = '0;
        for (int i = 0; i < DIGIT_COUNT; i++) begin
            if (w_byte_sel == 3'(i + 1)) begin
                w_store_byte = r_segment_store[i];
            end
        end
    end

    always_comb begin
        if (r_frame == FRAME_DATA) begin
            w_byte = CMD_DATA_SET;
        end else if (r_frame == FRAME_DISP) begin
            w_byte = CMD_DISP_CTRL | {5'd0, i_brightness};
        end else if (w_byte_sel == 3'd0) begin
            w_byte = CMD_ADDR_SET;
        end else if (r_blank) begin
            w_byte = '0;
        end else begin
            w_byte = {1'b0, w_store_byte};
        end
    end

    always_comb begin
        n_phase    = r_phase;
        n_frame    = r_frame;
        n_byte_idx = r_byte_idx;
        n_bit_idx  = r_bit_idx;
        n_shift    = r_shift;
        n_blank    = r_blank;
        n_clock    = r_clock;
        n_data     = r_data;
        n_done     = 1'b0;
        if (w_load) begin
            n_blank    = i_blank_request;
            n_frame    = FRAME_DATA;
            n_byte_idx = '0;
            n_bit_idx  = '0;
            n_phase    = PH_ARMED;
        end else if (w_tick) begin
            unique case (r_phase)
                PH_ARMED: begin
                    n_phase = PH_START_A;
                    n_clock = 1'b1;
                    n_data  = 1'b1;
                end
                PH_START_A: begin
                    n_phase = PH_START_B;
                    n_data  = 1'b0;
                end
                PH_START_B: begin
                    n_phase = PH_START_C;
                    n_clock = 1'b0;
                end
                PH_BIT_LOW: begin
                    n_phase = PH_BIT_HIGH;
                    n_clock = 1'b1;
                end
                PH_BIT_HIGH: begin
                    if (r_bit_idx == 3'd7) begin
                        n_phase = PH_ACK_REL;
                        n_data  = 1'b0;
                    end else begin
                        n_bit_idx = r_bit_idx + 3'd1;
                        n_shift   = {1'b0, r_shift[7:1]};
                        n_phase   = PH_BIT_LOW;
                        n_clock   = 1'b0;
                        n_data    = r_shift[1];
                    end
                end
                PH_ACK_REL: begin
                    n_phase = PH_ACK_LOW;
                    n_clock = 1'b0;
                end
                PH_ACK_HIGH: begin
                    n_phase = PH_ACK_END;
                    n_clock = 1'b0;
                end
                PH_START_C, PH_ACK_LOW, PH_ACK_END: begin
                    // A low data line at the acknowledge slot gets one extra
                    // clock pulse before the next byte or the stop.
                    if (r_phase == PH_ACK_LOW && !i_data_line_in) begin
                        n_phase = PH_ACK_HIGH;
                        n_clock = 1'b1;
                    end else begin
                        n_byte_idx = w_byte_sel;
                        if ({1'b0, w_byte_sel} < w_frame_bytes) begin
                            n_shift   = w_byte;
                            n_bit_idx = '0;
                            n_phase   = PH_BIT_LOW;
                            n_clock   = 1'b0;
                            n_data    = w_byte[0];
                        end else begin
                            n_phase = PH_STOP_A;
                            n_clock = 1'b0;
                            n_data  = 1'b0;
                        end
                    end
                end
                PH_STOP_A: begin
                    n_phase = PH_STOP_B;
                    n_clock = 1'b1;
                end
                PH_STOP_B: begin
                    n_data = 1'b1;
                    if (w_last_frame) begin
                        n_phase = PH_IDLE;
                        n_done  = 1'b1;
                    end else begin
                        n_frame    = r_frame + 2'd1;
                        n_byte_idx = '0;
                        n_phase    = PH_START_A;
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_frame    <= '0;
            r_byte_idx <= '0;
            r_bit_idx  <= '0;
            r_shift    <= '0;
            r_blank    <= 1'b0;
            r_clock    <= 1'b1;
            r_data     <= 1'b1;
        end else if (i_step) begin
            r_phase    <= n_phase;
            r_frame    <= n_frame;
            r_byte_idx <= n_byte_idx;
            r_bit_idx  <= n_bit_idx;
            r_shift    <= n_shift;
            r_blank    <= n_blank;
            r_clock    <= n_clock;
            r_data     <= n_data;
        end
    end

    // Positions beyond the four input digits are loaded with a dark pattern.
    for (genvar g = 0; g < DIGIT_COUNT; g++) begin : g_store
        if (g < 4) begin : g_digit
            always_ff @(posedge i_clk) begin
                if (w_load) begin
                    r_segment_store[g] <= seg_code(w_digit[g]);
                end
            end
        end else begin : g_dark
            always_ff @(posedge i_clk) begin
                if (w_load) begin
                    r_segment_store[g] <= '0;
                end
            end
        end
    end

    assign w_drive = !((n_phase == PH_ACK_REL) || (n_phase == PH_ACK_LOW) ||
                       (n_phase == PH_ACK_HIGH) || (n_phase == PH_ACK_END));

    assign o_pins.clock_pin     = n_clock;
    assign o_pins.data_pin      = w_drive & n_data;
    assign o_pins.data_drive    = w_drive;
    assign o_pins.busy_res      = (n_phase != PH_IDLE);
    assign o_pins.transfer_done = n_done;

endmodule

>>> src/four_digit_display_serial_writer_core.sv
// Four-digit seven-segment display writer for a two-wire display controller.
// A load item latches four digits and arms a transfer of three frames (data
// command, address command with one segment byte per digit, display control
// with the brightness register, left out on a blank request); every tick
// item then moves the clock and data pins one phase. Each accepted item gives
// exactly one result item with the pin levels, busy and done flags. The
// sequencer step is a single pass of logic from the state registers into the
// result register. An item can be accepted in every cycle in which the result
// register is empty or its item is taken in the same cycle; a result that the
// receiver holds off stalls the input. The result appears in the cycle after
// acceptance. Depends on fdsw_pkg, fdsw_seq and the macros header.
`include "four_digit_display_serial_writer_core_macros.svh"

module four_digit_display_serial_writer_core #(
    parameter int DIGIT_COUNT = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [2:0] i_cfg_data,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic       i_kind,
    input  logic [3:0] i_digit_thousands,
    input  logic [3:0] i_digit_hundreds,
    input  logic [3:0] i_digit_tens,
    input  logic [3:0] i_digit_units,
    input  logic       i_blank_request,
    input  logic       i_data_line_in,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic       o_clock_pin,
    output logic       o_data_pin,
    output logic       o_data_drive,
    output logic       o_busy_res,
    output logic       o_transfer_done
);
    import fdsw_pkg::*;

    logic [2:0] r_brightness;
    logic       r_out_valid;
    t_pins      r_out;
    t_pins      w_pins;
    logic       w_accept;

    assign o_in_stall = r_out_valid && i_out_stall;
    assign w_accept   = i_in_valid && !o_in_stall;

    fdsw_seq #(
        .DIGIT_COUNT (DIGIT_COUNT)
    ) u_seq (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_step            (w_accept),
        .i_kind            (i_kind),
        .i_digit_thousands (i_digit_thousands),
        .i_digit_hundreds  (i_digit_hundreds),
        .i_digit_tens      (i_digit_tens),
        .i_digit_units     (i_digit_units),
        .i_blank_request   (i_blank_request),
        .i_data_line_in    (i_data_line_in),
        .i_brightness      (r_brightness),
        .o_pins            (w_pins)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_brightness <= 3'd1;
        end else if (i_cfg_we) begin
            r_brightness <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out <= w_pins;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_clock_pin     = r_out.clock_pin;
    assign o_data_pin      = r_out.data_pin;
    assign o_data_drive    = r_out.data_drive;
    assign o_busy_res      = r_out.busy_res;
    assign o_transfer_done = r_out.transfer_done;

    `FDSW_ASSERT_SAME(a_released_low, o_out_valid && !o_data_drive, !o_data_pin,
        "data pin not low while released")
    `FDSW_ASSERT_SAME(a_done_idle, o_out_valid && o_transfer_done,
        !o_busy_res && o_data_pin && o_clock_pin && o_data_drive,
        "transfer done without idle bus")
    `FDSW_ASSERT_NEXT(a_accept_result, w_accept, o_out_valid,
        "accepted item gave no result")

endmodule
